// File: rtl/wrench_bias_gravity_filter_defines.svh
// Assertion macros for the wrench bias and gravity filter.
`ifndef WRENCH_BIAS_GRAVITY_FILTER_DEFINES_SVH
`define WRENCH_BIAS_GRAVITY_FILTER_DEFINES_SVH

`ifndef SYNTH
`define WBG_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wbg assertion failed");
`define WBG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wbg assertion failed");
`else
`define WBG_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define WBG_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/wbg_pkg.sv
`default_nettype none

package wbg_pkg;

    localparam int WRENCH_W  = 32;
    localparam int DIR_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_AXES  = 6;
    localparam int NUM_DIRS  = 3;

    localparam int SAMPLE_COUNT_DEF = 64;

    localparam int GRAV_W = 21;
    localparam logic signed [GRAV_W-1:0] GRAVITY_Q16 = 21'sd642689;
    localparam logic signed [CFG_W-1:0]  OFFSET_Z_RESET = 16'sd3015;

    localparam int COMP_W = WRENCH_W + 1;
    localparam int W_W    = COMP_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_LOAD_MASS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_OFFSET_Z = 2'd2;

    localparam int AX_FX = 0;
    localparam int AX_FY = 1;
    localparam int AX_FZ = 2;
    localparam int AX_TX = 3;
    localparam int AX_TY = 4;
    localparam int AX_TZ = 5;

    typedef struct packed {
        logic mul1;
        logic mul2;
        logic rnd1;
        logic mul3;
        logic rnd2;
    } t_load_ctl;

    typedef struct packed {
        logic comp;
        logic acc;
        logic avg;
        logic wdif;
        logic fmul;
        logic fsum;
    } t_lane_ctl;

endpackage

`default_nettype wire

// File: rtl/wbg_load.sv
`default_nettype none

module wbg_load (
    input  logic                                   i_clk,
    input  wbg_pkg::t_load_ctl                     i_ctl,
    input  logic        [wbg_pkg::CFG_W-1:0]       i_mass,
    input  logic signed [wbg_pkg::CFG_W-1:0]       i_offset_z,
    input  logic signed [wbg_pkg::DIR_W-1:0]       i_dir  [wbg_pkg::NUM_DIRS],
    output logic signed [wbg_pkg::WRENCH_W-1:0]    o_load [wbg_pkg::NUM_AXES]
);

    localparam int P_W  = wbg_pkg::CFG_W + 1 + wbg_pkg::DIR_W;
    localparam int Q_W  = P_W + wbg_pkg::GRAV_W;
    localparam int T_W  = wbg_pkg::CFG_W + wbg_pkg::WRENCH_W;
    localparam int F_SH = 22;
    localparam int T_SH = 16;
    localparam logic signed [Q_W-1:0] Q_HALF = Q_W'(64'sd1 <<< (F_SH - 1));
    localparam logic signed [T_W-1:0] T_HALF = T_W'(64'sd1 <<< (T_SH - 1));

    logic signed [P_W-1:0]               r_p   [wbg_pkg::NUM_DIRS];
    logic signed [Q_W-1:0]               r_q   [wbg_pkg::NUM_DIRS];
    logic signed [wbg_pkg::WRENCH_W-1:0] r_lf  [wbg_pkg::NUM_DIRS];
    logic signed [T_W-1:0]               r_t   [2];
    logic signed [wbg_pkg::WRENCH_W-1:0] r_lt  [2];
    logic signed [Q_W-1:0]               w_qr  [wbg_pkg::NUM_DIRS];
    logic signed [T_W-1:0]               w_tr  [2];
    logic signed [wbg_pkg::WRENCH_W-1:0] n_lf  [wbg_pkg::NUM_DIRS];
    logic signed [wbg_pkg::WRENCH_W-1:0] n_lt  [2];

    always_comb begin
        for (int i = 0; i < wbg_pkg::NUM_DIRS; i++) begin
            w_qr[i] = (r_q[i] + Q_HALF) >>> F_SH;
            n_lf[i] = -$signed(w_qr[i][wbg_pkg::WRENCH_W-1:0]);
        end
        for (int i = 0; i < 2; i++) begin
            w_tr[i] = (r_t[i] + T_HALF) >>> T_SH;
        end
        n_lt[0] = -$signed(w_tr[0][wbg_pkg::WRENCH_W-1:0]);
        n_lt[1] = $signed(w_tr[1][wbg_pkg::WRENCH_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < wbg_pkg::NUM_DIRS; i++) begin
            if (i_ctl.mul1) begin
                r_p[i] <= $signed({1'b0, i_mass}) * i_dir[i];
            end
            if (i_ctl.mul2) begin
                r_q[i] <= r_p[i] * wbg_pkg::GRAVITY_Q16;
            end
            if (i_ctl.rnd1) begin
                r_lf[i] <= n_lf[i];
            end
        end
        if (i_ctl.mul3) begin
            r_t[0] <= i_offset_z * r_lf[wbg_pkg::AX_FY];
            r_t[1] <= i_offset_z * r_lf[wbg_pkg::AX_FX];
        end
        if (i_ctl.rnd2) begin
            r_lt <= n_lt;
        end
    end

    assign o_load[wbg_pkg::AX_FX] = r_lf[wbg_pkg::AX_FX];
    assign o_load[wbg_pkg::AX_FY] = r_lf[wbg_pkg::AX_FY];
    assign o_load[wbg_pkg::AX_FZ] = r_lf[wbg_pkg::AX_FZ];
    assign o_load[wbg_pkg::AX_TX] = r_lt[0];
    assign o_load[wbg_pkg::AX_TY] = r_lt[1];
    assign o_load[wbg_pkg::AX_TZ] = '0;

endmodule

`default_nettype wire

// File: rtl/wbg_lane.sv
`default_nettype none

module wbg_lane #(
    parameter int SAMPLE_COUNT = wbg_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wbg_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [wbg_pkg::WRENCH_W-1:0] i_raw,
    input  logic signed [wbg_pkg::WRENCH_W-1:0] i_load,
    input  logic        [wbg_pkg::CFG_W-1:0]    i_gain,
    output logic signed [wbg_pkg::WRENCH_W-1:0] o_filt
);

    localparam int LOG2_N = $clog2(SAMPLE_COUNT);
    localparam int ACC_W  = wbg_pkg::COMP_W + LOG2_N;
    localparam int PK_W   = wbg_pkg::CFG_W + 1 + wbg_pkg::WRENCH_W;
    localparam int PT_W   = wbg_pkg::CFG_W + 2 + wbg_pkg::W_W;
    localparam int S_W    = PT_W + 1;
    localparam int F_SH   = 16;
    localparam int R_W    = S_W - F_SH;
    localparam int OW     = wbg_pkg::WRENCH_W;
    localparam logic [wbg_pkg::CFG_W:0] UNITY = {1'b1, {wbg_pkg::CFG_W{1'b0}}};
    localparam logic signed [S_W-1:0]   S_HALF = S_W'(64'sd1 <<< (F_SH - 1));
    localparam logic signed [OW-1:0]    SAT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0]    SAT_MIN = {1'b1, {(OW-1){1'b0}}};

    logic signed [wbg_pkg::COMP_W-1:0] r_comp;
    logic signed [ACC_W-1:0]           r_bias;
    logic signed [wbg_pkg::W_W-1:0]    r_w;
    logic signed [PK_W-1:0]            r_pk;
    logic signed [PT_W-1:0]            r_pt;
    logic signed [OW-1:0]              r_filt;
    logic        [wbg_pkg::CFG_W:0]    w_take;
    logic signed [S_W-1:0]             w_sum;
    logic signed [S_W-1:0]             w_shr;
    logic signed [R_W-1:0]             w_rnd;
    logic signed [OW-1:0]              n_filt;

    always_comb begin
        w_take = UNITY - {1'b0, i_gain};
        w_sum  = S_W'(r_pk) + S_W'(r_pt) + S_HALF;
        w_shr  = w_sum >>> F_SH;
        w_rnd  = w_shr[R_W-1:0];
        if (&w_rnd[R_W-1:OW-1] || ~|w_rnd[R_W-1:OW-1]) begin
            n_filt = w_rnd[OW-1:0];
        end else if (w_rnd[R_W-1]) begin
            n_filt = SAT_MIN;
        end else begin
            n_filt = SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
            r_filt <= '0;
        end else begin
            if (i_ctl.acc) begin
                r_bias <= r_bias + ACC_W'(r_comp);
            end else if (i_ctl.avg) begin
                r_bias <= r_bias >>> LOG2_N;
            end
            if (i_ctl.fsum) begin
                r_filt <= n_filt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.comp) begin
            r_comp <= wbg_pkg::COMP_W'(i_raw) - wbg_pkg::COMP_W'(i_load);
        end
        if (i_ctl.wdif) begin
            r_w <= wbg_pkg::W_W'(r_comp)
                 - wbg_pkg::W_W'($signed(r_bias[wbg_pkg::COMP_W-1:0]));
        end
        if (i_ctl.fmul) begin
            r_pk <= $signed({1'b0, i_gain}) * r_filt;
            r_pt <= $signed({1'b0, w_take}) * r_w;
        end
    end

    assign o_filt = r_filt;

endmodule

`default_nettype wire

// File: rtl/wrench_bias_gravity_filter.sv
// Six-axis wrench bias removal, tool gravity compensation and smoothing filter. One
// transaction in gives one transaction out. A new sample is accepted only once the last one
// has been loaded into the output register, in the idle state: a fixed sequencer walks the
// gravity load multiplies (three direction lanes, then the two torque products), the
// compensation and bias update, and the filter multiply-add that runs in six axis lanes
// side by side; the result then sits in an output register while the next sample is taken.
// A sample with pose_valid low passes through the same steps and changes no state. The
// bias is averaged over the first SAMPLE_COUNT valid samples (a power of two); bias_ready
// rises on the last of them, and the filtered outputs stay zero until then.
`default_nettype none

`include "wrench_bias_gravity_filter_defines.svh"

module wrench_bias_gravity_filter #(
    parameter int SAMPLE_COUNT = wbg_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_we,
    input  logic        [wbg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [wbg_pkg::CFG_W-1:0]     i_cfg_data,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_pose_valid,
    input  logic signed [wbg_pkg::WRENCH_W-1:0]  i_force_x,
    input  logic signed [wbg_pkg::WRENCH_W-1:0]  i_force_y,
    input  logic signed [wbg_pkg::WRENCH_W-1:0]  i_force_z,
    input  logic signed [wbg_pkg::WRENCH_W-1:0]  i_torque_x,
    input  logic signed [wbg_pkg::WRENCH_W-1:0]  i_torque_y,
    input  logic signed [wbg_pkg::WRENCH_W-1:0]  i_torque_z,
    input  logic signed [wbg_pkg::DIR_W-1:0]     i_gravity_dir_x,
    input  logic signed [wbg_pkg::DIR_W-1:0]     i_gravity_dir_y,
    input  logic signed [wbg_pkg::DIR_W-1:0]     i_gravity_dir_z,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [wbg_pkg::WRENCH_W-1:0]  o_filt_force_x,
    output logic signed [wbg_pkg::WRENCH_W-1:0]  o_filt_force_y,
    output logic signed [wbg_pkg::WRENCH_W-1:0]  o_filt_force_z,
    output logic signed [wbg_pkg::WRENCH_W-1:0]  o_filt_torque_x,
    output logic signed [wbg_pkg::WRENCH_W-1:0]  o_filt_torque_y,
    output logic signed [wbg_pkg::WRENCH_W-1:0]  o_filt_torque_z,
    output logic                                 o_bias_ready
);

    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLE_COUNT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_RND1,
        S_MUL3,
        S_RND2,
        S_COMP,
        S_ACC,
        S_AVG,
        S_WDIF,
        S_FMUL,
        S_FSUM,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic                                r_out_valid;
    logic signed [wbg_pkg::WRENCH_W-1:0] r_out_filt [wbg_pkg::NUM_AXES];
    logic                                r_out_ready;
    logic        [CNT_W-1:0]             r_count;
    logic                                r_ready;
    logic                                r_avg_pend;

    logic        [wbg_pkg::CFG_W-1:0]    r_load_mass;
    logic        [wbg_pkg::CFG_W-1:0]    r_filter_gain;
    logic signed [wbg_pkg::CFG_W-1:0]    r_load_offset_z;

    logic                                r_pose_valid;
    logic signed [wbg_pkg::WRENCH_W-1:0] r_raw [wbg_pkg::NUM_AXES];
    logic signed [wbg_pkg::DIR_W-1:0]    r_dir [wbg_pkg::NUM_DIRS];

    wbg_pkg::t_load_ctl                  w_load_ctl;
    wbg_pkg::t_lane_ctl                  w_lane_ctl;
    logic signed [wbg_pkg::WRENCH_W-1:0] w_load [wbg_pkg::NUM_AXES];
    logic signed [wbg_pkg::WRENCH_W-1:0] w_filt [wbg_pkg::NUM_AXES];
    logic                                w_in_acc;
    logic                                w_out_load;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_load_ctl.mul1 = (r_state == S_MUL1);
        w_load_ctl.mul2 = (r_state == S_MUL2);
        w_load_ctl.rnd1 = (r_state == S_RND1);
        w_load_ctl.mul3 = (r_state == S_MUL3);
        w_load_ctl.rnd2 = (r_state == S_RND2);
        w_lane_ctl.comp = (r_state == S_COMP);
        w_lane_ctl.acc  = (r_state == S_ACC) && r_pose_valid && !r_ready;
        w_lane_ctl.avg  = (r_state == S_AVG) && r_avg_pend;
        w_lane_ctl.wdif = (r_state == S_WDIF) && r_pose_valid && r_ready;
        w_lane_ctl.fmul = (r_state == S_FMUL) && r_pose_valid && r_ready;
        w_lane_ctl.fsum = (r_state == S_FSUM) && r_pose_valid && r_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_mass     <= '0;
            r_filter_gain   <= '0;
            r_load_offset_z <= wbg_pkg::OFFSET_Z_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wbg_pkg::REG_LOAD_MASS:     r_load_mass     <= i_cfg_data;
                wbg_pkg::REG_FILTER_GAIN:   r_filter_gain   <= i_cfg_data;
                wbg_pkg::REG_LOAD_OFFSET_Z: r_load_offset_z <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pose_valid            <= i_pose_valid;
            r_raw[wbg_pkg::AX_FX]   <= i_force_x;
            r_raw[wbg_pkg::AX_FY]   <= i_force_y;
            r_raw[wbg_pkg::AX_FZ]   <= i_force_z;
            r_raw[wbg_pkg::AX_TX]   <= i_torque_x;
            r_raw[wbg_pkg::AX_TY]   <= i_torque_y;
            r_raw[wbg_pkg::AX_TZ]   <= i_torque_z;
            r_dir[0]                <= i_gravity_dir_x;
            r_dir[1]                <= i_gravity_dir_y;
            r_dir[2]                <= i_gravity_dir_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_avg_pend  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_filt  <= w_filt;
                r_out_ready <= r_ready;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_RND1;
                S_RND1: r_state <= S_MUL3;
                S_MUL3: r_state <= S_RND2;
                S_RND2: r_state <= S_COMP;
                S_COMP: r_state <= S_ACC;
                S_ACC: begin
                    if (w_lane_ctl.acc) begin
                        r_count    <= r_count + CNT_W'(1);
                        r_avg_pend <= ((r_count + CNT_W'(1)) == CNT_FULL);
                    end
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    if (r_avg_pend) begin
                        r_ready    <= 1'b1;
                        r_avg_pend <= 1'b0;
                    end
                    r_state <= S_WDIF;
                end
                S_WDIF: r_state <= S_FMUL;
                S_FMUL: r_state <= S_FSUM;
                S_FSUM: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    wbg_load u_load (
        .i_clk      (i_clk),
        .i_ctl      (w_load_ctl),
        .i_mass     (r_load_mass),
        .i_offset_z (r_load_offset_z),
        .i_dir      (r_dir),
        .o_load     (w_load)
    );

    for (genvar g = 0; g < wbg_pkg::NUM_AXES; g++) begin : g_lane
        wbg_lane #(
            .SAMPLE_COUNT (SAMPLE_COUNT)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_lane_ctl),
            .i_raw   (r_raw[g]),
            .i_load  (w_load[g]),
            .i_gain  (r_filter_gain),
            .o_filt  (w_filt[g])
        );
    end

    assign o_out_valid     = r_out_valid;
    assign o_filt_force_x  = r_out_filt[wbg_pkg::AX_FX];
    assign o_filt_force_y  = r_out_filt[wbg_pkg::AX_FY];
    assign o_filt_force_z  = r_out_filt[wbg_pkg::AX_FZ];
    assign o_filt_torque_x = r_out_filt[wbg_pkg::AX_TX];
    assign o_filt_torque_y = r_out_filt[wbg_pkg::AX_TY];
    assign o_filt_torque_z = r_out_filt[wbg_pkg::AX_TZ];
    assign o_bias_ready    = r_out_ready;

    `WBG_ASSERT_NEXT(a_ready_sticky, i_clk, i_rst_n, r_ready, r_ready)
    `WBG_ASSERT_IMP(a_ready_count, i_clk, i_rst_n, r_ready, r_count == CNT_FULL)
    `WBG_ASSERT_IMP(a_filter_needs_bias, i_clk, i_rst_n, w_lane_ctl.fsum, r_ready)
    `WBG_ASSERT_IMP(a_pend_before_ready, i_clk, i_rst_n, r_avg_pend, !r_ready)

endmodule

`default_nettype wire

// File: verif/tb_wrench_bias_gravity_filter.sv
module tb_wrench_bias_gravity_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_AXES = wbg_pkg::NUM_AXES;
    localparam int NUM_DIRS = wbg_pkg::NUM_DIRS;
    localparam int WRENCH_W = wbg_pkg::WRENCH_W;
    localparam int DIR_W    = wbg_pkg::DIR_W;
    localparam int CFG_W    = wbg_pkg::CFG_W;
    localparam int AX_FX    = wbg_pkg::AX_FX;
    localparam int AX_FY    = wbg_pkg::AX_FY;
    localparam int AX_FZ    = wbg_pkg::AX_FZ;
    localparam int AX_TX    = wbg_pkg::AX_TX;
    localparam int AX_TY    = wbg_pkg::AX_TY;
    localparam int AX_TZ    = wbg_pkg::AX_TZ;
    localparam logic signed [CFG_W-1:0] OFFSET_Z_RESET = wbg_pkg::OFFSET_Z_RESET;

    localparam int BIAS_SAMPLES    = wbg_pkg::SAMPLE_COUNT_DEF;
    localparam int BIAS_SHIFT      = $clog2(BIAS_SAMPLES);
    localparam int DIRECTED_ROWS   = 20;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int MAX_PRINTED     = 40;
    localparam int SETTLE_CYCLES   = 20;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic                              pose_valid;
        logic [NUM_AXES-1:0][WRENCH_W-1:0] wrench;
        logic [NUM_DIRS-1:0][DIR_W-1:0]    dir;
    } t_sample;

    typedef struct packed {
        logic [NUM_AXES-1:0][WRENCH_W-1:0] filt;
        logic                              bias_ready;
    } t_wrench_out;

    typedef struct packed {
        logic             apply_cfg;
        logic [CFG_W-1:0] mass;
        logic [CFG_W-1:0] gain;
        logic [CFG_W-1:0] offset_z;
        t_sample          smp;
    } t_directed_row;

    localparam t_wrench_out FILTER_AT_REST = '0;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [wbg_pkg::CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_W-1:0]            i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_pose_valid;
    logic signed [WRENCH_W-1:0]  i_force_x;
    logic signed [WRENCH_W-1:0]  i_force_y;
    logic signed [WRENCH_W-1:0]  i_force_z;
    logic signed [WRENCH_W-1:0]  i_torque_x;
    logic signed [WRENCH_W-1:0]  i_torque_y;
    logic signed [WRENCH_W-1:0]  i_torque_z;
    logic signed [DIR_W-1:0]     i_gravity_dir_x;
    logic signed [DIR_W-1:0]     i_gravity_dir_y;
    logic signed [DIR_W-1:0]     i_gravity_dir_z;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [WRENCH_W-1:0]  o_filt_force_x;
    logic signed [WRENCH_W-1:0]  o_filt_force_y;
    logic signed [WRENCH_W-1:0]  o_filt_force_z;
    logic signed [WRENCH_W-1:0]  o_filt_torque_x;
    logic signed [WRENCH_W-1:0]  o_filt_torque_y;
    logic signed [WRENCH_W-1:0]  o_filt_torque_z;
    logic                        o_bias_ready;

    wrench_bias_gravity_filter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pose_valid    (i_pose_valid),
        .i_force_x       (i_force_x),
        .i_force_y       (i_force_y),
        .i_force_z       (i_force_z),
        .i_torque_x      (i_torque_x),
        .i_torque_y      (i_torque_y),
        .i_torque_z      (i_torque_z),
        .i_gravity_dir_x (i_gravity_dir_x),
        .i_gravity_dir_y (i_gravity_dir_y),
        .i_gravity_dir_z (i_gravity_dir_z),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_filt_force_x  (o_filt_force_x),
        .o_filt_force_y  (o_filt_force_y),
        .o_filt_force_z  (o_filt_force_z),
        .o_filt_torque_x (o_filt_torque_x),
        .o_filt_torque_y (o_filt_torque_y),
        .o_filt_torque_z (o_filt_torque_z),
        .o_bias_ready    (o_bias_ready)
    );

    logic [CFG_W-1:0]           mass_cfg;
    logic [CFG_W-1:0]           gain_cfg;
    logic signed [CFG_W-1:0]    offset_z_cfg;
    longint                     bias_sum [NUM_AXES];
    int unsigned                bias_count;
    bit                         bias_done;
    logic signed [WRENCH_W-1:0] filt_state [NUM_AXES];

    t_wrench_out expected_wrench_q [$];
    logic        typed_pending;
    bit          no_stall;
    int          errors;
    int          n_accepted;
    int          n_with_pose;
    int          n_checked;
    int          n_settings;

    string axis_name [NUM_AXES] = '{"filt_force_x", "filt_force_y", "filt_force_z",
                                    "filt_torque_x", "filt_torque_y", "filt_torque_z"};

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint round_half_up(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [WRENCH_W-1:0] clamp_to_word(longint v);
        if (v > WORD_MAX) begin
            return WORD_MAX[WRENCH_W-1:0];
        end
        if (v < WORD_MIN) begin
            return WORD_MIN[WRENCH_W-1:0];
        end
        return v[WRENCH_W-1:0];
    endfunction

    function automatic t_wrench_out compensate_and_smooth(t_sample s);
        longint      mg;
        longint      load [NUM_AXES];
        longint      comp [NUM_AXES];
        longint      keep;
        longint      take;
        longint      w;
        t_wrench_out r;
        if (s.pose_valid) begin
            mg = longint'(mass_cfg) * longint'(wbg_pkg::GRAVITY_Q16);
            for (int i = 0; i < NUM_DIRS; i++) begin
                load[i] = -round_half_up(mg * longint'($signed(s.dir[i])), 22);
            end
            load[AX_TX] = -round_half_up(longint'(offset_z_cfg) * load[AX_FY], 16);
            load[AX_TY] = round_half_up(longint'(offset_z_cfg) * load[AX_FX], 16);
            load[AX_TZ] = 0;
            for (int i = 0; i < NUM_AXES; i++) begin
                comp[i] = longint'($signed(s.wrench[i])) - load[i];
            end
            if (!bias_done) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    bias_sum[i] += comp[i];
                end
                bias_count++;
                if (bias_count >= BIAS_SAMPLES) begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        bias_sum[i] = bias_sum[i] >>> BIAS_SHIFT;
                    end
                    bias_done = 1'b1;
                end
            end
            if (bias_done) begin
                keep = longint'(gain_cfg);
                take = 65536 - keep;
                for (int i = 0; i < NUM_AXES; i++) begin
                    w = comp[i] - bias_sum[i];
                    filt_state[i] = clamp_to_word(
                        round_half_up(keep * longint'(filt_state[i]) + take * w, 16));
                end
            end
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            r.filt[i] = filt_state[i];
        end
        r.bias_ready = bias_done;
        return r;
    endfunction

    function automatic t_sample make_sample(logic pv,
                                            logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                                            logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                            logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
        t_sample s;
        s.pose_valid   = pv;
        s.wrench[AX_FX] = fx;
        s.wrench[AX_FY] = fy;
        s.wrench[AX_FZ] = fz;
        s.wrench[AX_TX] = tx;
        s.wrench[AX_TY] = ty;
        s.wrench[AX_TZ] = tz;
        s.dir[0] = dx;
        s.dir[1] = dy;
        s.dir[2] = dz;
        return s;
    endfunction

    function automatic t_directed_row make_row(logic apply, logic [15:0] mass,
                                               logic [15:0] gain, logic [15:0] oz,
                                               t_sample smp);
        t_directed_row r;
        r.apply_cfg = apply;
        r.mass      = mass;
        r.gain      = gain;
        r.offset_z  = oz;
        r.smp       = smp;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     n_checked, what, got, want);
        end
    endtask

    // drop valid, hold until every pending result has been taken, then resume on a rising edge
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (expected_wrench_q.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [CFG_W-1:0] mass, logic [CFG_W-1:0] gain,
                              logic [CFG_W-1:0] oz);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wbg_pkg::REG_LOAD_MASS;
        i_cfg_data <= mass;
        @(posedge i_clk);
        i_cfg_idx  <= wbg_pkg::REG_FILTER_GAIN;
        i_cfg_data <= gain;
        @(posedge i_clk);
        i_cfg_idx  <= wbg_pkg::REG_LOAD_OFFSET_Z;
        i_cfg_data <= oz;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        mass_cfg     = mass;
        gain_cfg     = gain;
        offset_z_cfg = oz;
        n_settings++;
    endtask

    task automatic push_sample(t_sample s, logic typed);
        if (!no_stall && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_pose_valid    <= s.pose_valid;
        i_force_x       <= s.wrench[AX_FX];
        i_force_y       <= s.wrench[AX_FY];
        i_force_z       <= s.wrench[AX_FZ];
        i_torque_x      <= s.wrench[AX_TX];
        i_torque_y      <= s.wrench[AX_TY];
        i_torque_z      <= s.wrench[AX_TZ];
        i_gravity_dir_x <= s.dir[0];
        i_gravity_dir_y <= s.dir[1];
        i_gravity_dir_z <= s.dir[2];
        typed_pending   <= typed;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && !no_stall && $urandom_range(99) < 2) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_wrench_out got;
        t_wrench_out want;
        t_wrench_out predicted;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.filt[AX_FX] = o_filt_force_x;
            got.filt[AX_FY] = o_filt_force_y;
            got.filt[AX_FZ] = o_filt_force_z;
            got.filt[AX_TX] = o_filt_torque_x;
            got.filt[AX_TY] = o_filt_torque_y;
            got.filt[AX_TZ] = o_filt_torque_z;
            got.bias_ready  = o_bias_ready;
            if (expected_wrench_q.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = expected_wrench_q.pop_front();
                for (int i = 0; i < NUM_AXES; i++) begin
                    if (got.filt[i] !== want.filt[i]) begin
                        report_mismatch(axis_name[i], $signed(got.filt[i]),
                                        $signed(want.filt[i]));
                    end
                end
                if (got.bias_ready !== want.bias_ready) begin
                    report_mismatch("bias_ready", got.bias_ready, want.bias_ready);
                end
            end
            n_checked++;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predicted = compensate_and_smooth(make_sample(i_pose_valid,
                i_force_x, i_force_y, i_force_z, i_torque_x, i_torque_y, i_torque_z,
                i_gravity_dir_x, i_gravity_dir_y, i_gravity_dir_z));
            expected_wrench_q.insert(expected_wrench_q.size(),
                                     typed_pending ? FILTER_AT_REST : predicted);
            n_accepted++;
            if (i_pose_valid) begin
                n_with_pose++;
            end
        end
    end

    initial begin
        t_directed_row rows [DIRECTED_ROWS];
        t_sample       s;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        i_in_valid      <= 1'b0;
        i_pose_valid    <= 1'b0;
        i_force_x       <= '0;
        i_force_y       <= '0;
        i_force_z       <= '0;
        i_torque_x      <= '0;
        i_torque_y      <= '0;
        i_torque_z      <= '0;
        i_gravity_dir_x <= '0;
        i_gravity_dir_y <= '0;
        i_gravity_dir_z <= '0;
        typed_pending   <= 1'b0;
        no_stall        = 1'b0;
        errors          = 0;
        n_accepted      = 0;
        n_with_pose     = 0;
        n_checked       = 0;
        n_settings      = 0;
        mass_cfg        = '0;
        gain_cfg        = '0;
        offset_z_cfg    = OFFSET_Z_RESET;
        bias_count      = 0;
        bias_done       = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            bias_sum[i]   = 0;
            filt_state[i] = '0;
        end

        // all directed rows fall inside bias averaging, so the filter stays at rest
        rows[0]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h4000));
        rows[1]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 16'h4000, 16'h4000, 16'h4000));
        rows[2]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 16'hC000, 16'hC000, 16'hC000));
        rows[3]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b0,
                   32'h12345678, 32'h9ABCDEF0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                   32'h00000001, 16'h8000, 16'h8000, 16'h8000));
        rows[4]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                   32'h80000000, 16'h8000, 16'h8000, 16'h8000));
        rows[5]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'hFFFFFFFF, 32'h00000001, 32'hFFFF0000, 32'h00010000, 32'h0,
                   32'h80000001, 16'h4000, 16'hC000, 16'h0000));
        rows[6]  = make_row(1'b1, 16'hFFFF, 16'hFFFF, 16'h8000, make_sample(1'b1,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 16'h4000, 16'h4000, 16'h4000));
        rows[7]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 16'hC000, 16'hC000, 16'hC000));
        rows[8]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000));
        rows[9]  = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b0,
                   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   32'hFFFFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        rows[10] = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000,
                   32'h00010000, 16'h0000, 16'h0000, 16'h4000));
        rows[11] = make_row(1'b1, 16'h0000, 16'h0000, 16'h7FFF, make_sample(1'b1,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 16'h4000, 16'h4000, 16'hC000));
        rows[12] = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 16'hC000, 16'h4000, 16'h4000));
        rows[13] = make_row(1'b1, 16'h8000, 16'h8000, OFFSET_Z_RESET, make_sample(1'b1,
                   32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555,
                   32'h55555555, 16'h2D41, 16'h0000, 16'h2D41));
        rows[14] = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA,
                   32'hAAAAAAAA, 16'hD2BF, 16'hD2BF, 16'h0000));
        rows[15] = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b0,
                   32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000));
        rows[16] = make_row(1'b1, 16'hFFFF, 16'h0000, 16'h7FFF, make_sample(1'b1,
                   32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000));
        rows[17] = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                   32'h80000000, 16'h4000, 16'h4000, 16'h4000));
        rows[18] = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h13579BDF, 32'hECA86420, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h00FF00FF,
                   32'hFF00FF00, 16'h1234, 16'hEDCC, 16'h0800));
        rows[19] = make_row(1'b0, 16'h0000, 16'h0000, 16'h0000, make_sample(1'b1,
                   32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 16'hC000, 16'hC000, 16'hC000));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].apply_cfg) begin
                wait_idle();
                set_config(rows[k].mass, rows[k].gain, rows[k].offset_z);
            end
            push_sample(rows[k].smp, 1'b1);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: set_config(16'($urandom), 16'h0000, OFFSET_Z_RESET);
                1: set_config(16'h0000, 16'h0000, 16'h8000);
                2: set_config(16'hFFFF, 16'hFFFF, 16'h7FFF);
                3: set_config(16'hFFFF, 16'h0000, 16'h8000);
                4: set_config(16'h0000, 16'hFFFF, 16'h0000);
                default: set_config(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            no_stall = (p == 5);
            repeat (ITEMS_PER_PHASE) begin
                s.pose_valid = ($urandom_range(99) < 88);
                for (int a = 0; a < NUM_AXES; a++) begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: s.wrench[a] = $urandom;
                        8:          s.wrench[a] = 32'h7FFFFFFF;
                        9:          s.wrench[a] = 32'h80000000;
                        default:    s.wrench[a] = $urandom_range(0, 32'h7FFFFF) - 32'h400000;
                    endcase
                end
                for (int d = 0; d < NUM_DIRS; d++) begin
                    case ($urandom_range(19))
                        0:       s.dir[d] = 16'($urandom);
                        1:       s.dir[d] = 16'h8000;
                        2:       s.dir[d] = 16'h4000;
                        3:       s.dir[d] = 16'hC000;
                        default: s.dir[d] = 16'($urandom_range(0, 32768) - 16384);
                    endcase
                end
                push_sample(s, 1'b0);
            end
        end
        no_stall = 1'b0;

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_wrench_q.size() != 0) begin
            report_mismatch("results never delivered", expected_wrench_q.size(), 0);
        end

        $display("summary: %0d samples accepted, %0d with pose, %0d results checked",
                 n_accepted, n_with_pose, n_checked);
        $display("summary: %0d register settings, bias %s, %0d mismatches",
                 n_settings, bias_done ? "averaged" : "still accumulating", errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/wbg_pkg.sv
rtl/wbg_load.sv
rtl/wbg_lane.sv
rtl/wrench_bias_gravity_filter.sv
verif/tb_wrench_bias_gravity_filter.sv
